// ----- hw/rtl/crp_pkg.sv -----
// Package: shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package crp_pkg;
  localparam int MAX_POINTS = 64;
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int COORD_W = 32;
  localparam int PT_W = 3 * COORD_W;
  localparam int T_W = 17;
  localparam int S_W = 40;
  localparam logic [T_W-1:0] T_AIM = 17'd655;
  localparam logic [15:0] SPEED_RESET = 16'd128;
  localparam logic [6:0] NUM_POINTS_RESET = 7'd4;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_TICK = 2'd2
  } mode_t;

  typedef enum logic {
    REG_SPEED = 1'b0,
    REG_NUM_POINTS = 1'b1
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INC, ST_READ, ST_INIT, ST_MUL, ST_ADD, ST_STORE, ST_OUT
  } state_t;

  typedef struct packed {
    logic wr;
    logic restart;
    logic tick;
    logic upd;
    logic [1:0] rd_k;
    logic cap;
    logic [1:0] cap_k;
    logic init;
    logic mul;
    logic add;
    logic [1:0] step;
    logic store;
    logic [1:0] axis;
    logic aim;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic out_valid;
  } status_t;
endpackage

// ----- hw/rtl/catmull_rom_path_follower.sv -----
// Top level: Catmull-Rom camera path follower with APB configuration.
`timescale 1ns / 1ps
// Load and restart requests complete as they are accepted. A tick request while
// moving computes the speed product, then the t update, then four point reads
// through the read port of the point RAM, then Horner steps per axis and
// parameter value (cam and aim, three axes each) on the one shared 40x19
// multiplier before its result is registered. Ticks while halted and mode 3 are
// dropped. The result stays in the output register until taken,
// while the next request may already be accepted.
module catmull_rom_path_follower (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [5:0]         point_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [15:0]        delta_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] cam_x,
  output logic signed [31:0] cam_y,
  output logic signed [31:0] cam_z,
  output logic signed [31:0] aim_x,
  output logic signed [31:0] aim_y,
  output logic signed [31:0] aim_z,
  output logic [5:0]         segment,
  output logic [16:0]        param_t,
  output logic               finished
);
  logic [15:0] speed;
  logic [6:0] num_points;
  crp_pkg::cmd_t cmd;
  crp_pkg::status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= crp_pkg::SPEED_RESET;
      num_points <= crp_pkg::NUM_POINTS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (crp_pkg::reg_t'(paddr[2]))
        crp_pkg::REG_SPEED: speed <= pwdata[15:0];
        crp_pkg::REG_NUM_POINTS: num_points <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (crp_pkg::reg_t'(paddr[2]))
      crp_pkg::REG_SPEED: prdata = {16'd0, speed};
      crp_pkg::REG_NUM_POINTS: prdata = {25'd0, num_points};
      default: prdata = '0;
    endcase
  end

  crp_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .out_ready(out_ready),
    .status(status),
    .cmd(cmd)
  );

  crp_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .speed(speed),
    .num_points(num_points),
    .point_index(point_index),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .delta_time(delta_time),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .cam_x(cam_x),
    .cam_y(cam_y),
    .cam_z(cam_z),
    .aim_x(aim_x),
    .aim_y(aim_y),
    .aim_z(aim_z),
    .segment(segment),
    .param_t(param_t),
    .finished(finished)
  );
endmodule

// ----- hw/rtl/crp_ram.sv -----
// Generic single write port, registered read port RAM.
`timescale 1ns / 1ps
module crp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/crp_dp.sv -----
// Datapath: point store, path state, shared Horner multiplier and output registers.
`timescale 1ns / 1ps
module crp_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  crp_pkg::cmd_t                    cmd,
  output crp_pkg::status_t                 status,
  input  logic [15:0]                      speed,
  input  logic [6:0]                       num_points,
  input  logic [5:0]                       point_index,
  input  logic signed [31:0]               point_x,
  input  logic signed [31:0]               point_y,
  input  logic signed [31:0]               point_z,
  input  logic [15:0]                      delta_time,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [31:0]               cam_x,
  output logic signed [31:0]               cam_y,
  output logic signed [31:0]               cam_z,
  output logic signed [31:0]               aim_x,
  output logic signed [31:0]               aim_y,
  output logic signed [31:0]               aim_z,
  output logic [5:0]                       segment,
  output logic [16:0]                      param_t,
  output logic                             finished
);
  logic [crp_pkg::ADDR_W-1:0] seg;
  logic [crp_pkg::T_W-1:0] t_val;
  logic halted;
  logic fin;
  logic [31:0] inc_prod;
  logic [crp_pkg::PT_W-1:0] pts [4];
  logic [crp_pkg::PT_W-1:0] rdata;
  logic [crp_pkg::ADDR_W-1:0] raddr;
  logic signed [crp_pkg::S_W-1:0] s;
  logic signed [crp_pkg::S_W+18:0] prod;
  logic signed [31:0] res [2][3];

  logic [15:0] inc16;
  logic [17:0] tsum;
  logic [16:0] tsat;
  logic can_adv;
  logic [crp_pkg::CNT_W-1:0] n;
  logic [7:0] seg_e;
  logic full;
  logic [crp_pkg::ADDR_W-1:0] sel;
  logic signed [crp_pkg::S_W-1:0] p0, p1, p2, p3, ca, cb, cc, cd, coef;
  logic [17:0] tt;
  logic signed [crp_pkg::S_W-1:0] sh;
  logic signed [31:0] sat;

  crp_ram #(.WIDTH(crp_pkg::PT_W), .DEPTH(crp_pkg::MAX_POINTS)) u_ram (
    .clk(clk),
    .we(cmd.wr),
    .waddr(point_index[crp_pkg::ADDR_W-1:0]),
    .wdata({point_z, point_y, point_x}),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign status.halted = halted;
  assign status.out_valid = out_valid;

  always_comb begin
    inc16 = (|inc_prod[31:24]) ? 16'hFFFF : inc_prod[23:8];
    tsum = {1'b0, t_val} + {2'b0, inc16};
    tsat = tsum[17] ? 17'h1FFFF : tsum[16:0];
    can_adv = ($signed({2'b0, seg}) < ($signed({1'b0, num_points}) - 8'sd3))
              && (seg != 6'd63);
    n = (num_points > 7'(crp_pkg::MAX_POINTS)) ? crp_pkg::CNT_W'(crp_pkg::MAX_POINTS)
        : crp_pkg::CNT_W'(num_points);
    seg_e = {2'b0, seg};
    full = 1'b0;
    if (seg_e >= 8'(n)) begin
      sel = (n == '0) ? '0 : crp_pkg::ADDR_W'(n - 1'b1);
    end else begin
      sel = seg;
      full = (seg != '0) && ((seg_e + 8'd2) < 8'(n));
    end
    raddr = full ? (seg - 1'b1 + crp_pkg::ADDR_W'(cmd.rd_k)) : sel;

    p0 = crp_pkg::S_W'($signed(pts[0][cmd.axis*32 +: 32]));
    p1 = crp_pkg::S_W'($signed(pts[1][cmd.axis*32 +: 32]));
    p2 = crp_pkg::S_W'($signed(pts[2][cmd.axis*32 +: 32]));
    p3 = crp_pkg::S_W'($signed(pts[3][cmd.axis*32 +: 32]));
    ca = p1 <<< 1;
    cb = p2 - p0;
    cc = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
    cd = (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3 - p0;
    case (cmd.step)
      2'd0: coef = cc;
      2'd1: coef = cb;
      default: coef = ca;
    endcase
    tt = cmd.aim ? ({1'b0, t_val} + {1'b0, crp_pkg::T_AIM}) : {1'b0, t_val};
    sh = s >>> 1;
    if (sh > 40'sd2147483647) begin
      sat = 32'sh7FFFFFFF;
    end else if (sh < -40'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= crp_pkg::ADDR_W'(1);
      t_val <= '0;
      halted <= 1'b1;
      fin <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.restart) begin
        seg <= crp_pkg::ADDR_W'(1);
        t_val <= '0;
        halted <= 1'b0;
      end
      if (cmd.upd) begin
        fin <= 1'b0;
        t_val <= tsat;
        if (tsat[16]) begin
          if (can_adv) begin
            seg <= seg + 1'b1;
            t_val <= {1'b0, tsat[15:0]};
          end else begin
            halted <= 1'b1;
            fin <= 1'b1;
          end
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      inc_prod <= speed * delta_time;
    end
    if (cmd.cap) begin
      pts[cmd.cap_k] <= rdata;
    end
    if (cmd.init) begin
      s <= cd;
    end
    if (cmd.mul) begin
      prod <= s * $signed({1'b0, tt});
    end
    if (cmd.add) begin
      s <= prod[crp_pkg::S_W+15:16] + coef;
    end
    if (cmd.store) begin
      res[cmd.aim][cmd.axis] <= full ? sat : $signed(pts[1][cmd.axis*32 +: 32]);
    end
    if (cmd.out_load) begin
      cam_x <= res[0][0];
      cam_y <= res[0][1];
      cam_z <= res[0][2];
      aim_x <= res[1][0];
      aim_y <= res[1][1];
      aim_z <= res[1][2];
      segment <= seg;
      param_t <= t_val;
      finished <= fin;
    end
  end
endmodule

// ----- hw/rtl/crp_ctrl.sv -----
// Controller: request decode and sequencing of point reads and Horner steps.
`timescale 1ns / 1ps
module crp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       mode,
  input  logic             out_ready,
  input  crp_pkg::status_t status,
  output crp_pkg::cmd_t    cmd
);
  crp_pkg::state_t state, state_next;
  logic [2:0] rd_cnt, rd_cnt_next;
  logic [1:0] step, step_next;
  logic [1:0] axis, axis_next;
  logic aim, aim_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crp_pkg::ST_IDLE;
      rd_cnt <= '0;
      step <= '0;
      axis <= '0;
      aim <= 1'b0;
    end else begin
      state <= state_next;
      rd_cnt <= rd_cnt_next;
      step <= step_next;
      axis <= axis_next;
      aim <= aim_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_cnt_next = rd_cnt;
    step_next = step;
    axis_next = axis;
    aim_next = aim;
    in_ready = 1'b0;
    cmd = '0;
    cmd.step = step;
    cmd.axis = axis;
    cmd.aim = aim;
    cmd.rd_k = rd_cnt[1:0];
    cmd.cap_k = rd_cnt[1:0] - 2'd1;
    unique case (state)
      crp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (mode)
            crp_pkg::MODE_LOAD: cmd.wr = 1'b1;
            crp_pkg::MODE_RESTART: cmd.restart = 1'b1;
            crp_pkg::MODE_TICK: begin
              if (!status.halted) begin
                cmd.tick = 1'b1;
                state_next = crp_pkg::ST_INC;
              end
            end
            default: ;
          endcase
        end
      end
      crp_pkg::ST_INC: begin
        cmd.upd = 1'b1;
        rd_cnt_next = '0;
        state_next = crp_pkg::ST_READ;
      end
      crp_pkg::ST_READ: begin
        cmd.cap = (rd_cnt != 3'd0);
        if (rd_cnt == 3'd4) begin
          axis_next = '0;
          aim_next = 1'b0;
          state_next = crp_pkg::ST_INIT;
        end else begin
          rd_cnt_next = rd_cnt + 3'd1;
        end
      end
      crp_pkg::ST_INIT: begin
        cmd.init = 1'b1;
        step_next = '0;
        state_next = crp_pkg::ST_MUL;
      end
      crp_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = crp_pkg::ST_ADD;
      end
      crp_pkg::ST_ADD: begin
        cmd.add = 1'b1;
        if (step == 2'd2) begin
          state_next = crp_pkg::ST_STORE;
        end else begin
          step_next = step + 2'd1;
          state_next = crp_pkg::ST_MUL;
        end
      end
      crp_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        state_next = crp_pkg::ST_INIT;
        if (axis == 2'd2) begin
          axis_next = '0;
          if (aim) begin
            state_next = crp_pkg::ST_OUT;
          end else begin
            aim_next = 1'b1;
          end
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      crp_pkg::ST_OUT: begin
        if (!status.out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = crp_pkg::ST_IDLE;
        end
      end
      default: state_next = crp_pkg::ST_IDLE;
    endcase
  end
endmodule
